### hw/rtl/lcd_pkg.sv
// Shared types and character constants for the line command decoder.
package lcd_pkg;

  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharVtab  = 8'h0B;
  localparam logic [7:0] CharFf    = 8'h0C;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowZ  = 8'h7A;
  localparam logic [7:0] CaseGap   = 8'h20;
  localparam logic [7:0] CharF     = 8'h46;
  localparam logic [7:0] CharL     = 8'h4C;
  localparam logic [7:0] CharR     = 8'h52;
  localparam logic [7:0] CharS     = 8'h53;
  localparam logic [7:0] CharP     = 8'h50;

  localparam int LenShort   = 1;
  localparam int LenForward = 7;
  localparam int LenLeft    = 4;
  localparam int LenRight   = 5;
  localparam int LenStop    = 4;
  localparam int LenPing    = 4;

  typedef enum logic [2:0] {
    EV_FORWARD  = 3'd0,
    EV_LEFT     = 3'd1,
    EV_RIGHT    = 3'd2,
    EV_STOP     = 3'd3,
    EV_PING     = 3'd4,
    EV_UNKNOWN  = 3'd5,
    EV_OVERLONG = 3'd6
  } event_kind_t;

  typedef struct packed {
    logic        valid;
    event_kind_t kind;
    logic [31:0] accepted;
    logic [31:0] rejected;
  } lcd_result_t;

endpackage

### hw/rtl/lcd_line_tracker.sv
// Line state, command judging and event counters for one byte per step.
module lcd_line_tracker #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  output lcd_pkg::lcd_result_t result
);

  localparam int PosW = $clog2(LINE_CAPACITY);
  localparam logic [PosW-1:0] LastPos = PosW'(LINE_CAPACITY - 1);

  logic [PosW-1:0] line_length, line_length_next;
  logic [PosW-1:0] text_start, text_start_next;
  logic [PosW-1:0] text_end, text_end_next;
  logic [7:0]      first_letter, first_letter_next;
  logic            seen_text, seen_text_next;
  logic [31:0]     accepted_count, accepted_count_next;
  logic [31:0]     rejected_count, rejected_count_next;

  logic                 is_eol, is_blank, has_room, matched;
  logic [PosW-1:0]      text_len;
  logic [7:0]           upper;
  lcd_pkg::event_kind_t judged;

  assign is_eol   = (rx_byte == lcd_pkg::CharLf) || (rx_byte == lcd_pkg::CharCr);
  assign is_blank = (rx_byte == lcd_pkg::CharSpace) || (rx_byte == lcd_pkg::CharTab) ||
                    (rx_byte == lcd_pkg::CharVtab) || (rx_byte == lcd_pkg::CharFf);
  assign has_room = line_length < LastPos;
  assign text_len = text_end - text_start;
  assign upper    = (first_letter >= lcd_pkg::CharLowA && first_letter <= lcd_pkg::CharLowZ)
                    ? first_letter - lcd_pkg::CaseGap : first_letter;

  // Only the first letter and trimmed length decide; the word body is never kept.
  always_comb begin
    judged = lcd_pkg::EV_UNKNOWN;
    if (seen_text && text_end > text_start) begin
      priority if (upper == lcd_pkg::CharF && (text_len == PosW'(lcd_pkg::LenShort) ||
                   text_len == PosW'(lcd_pkg::LenForward))) begin
        judged = lcd_pkg::EV_FORWARD;
      end else if (upper == lcd_pkg::CharL && (text_len == PosW'(lcd_pkg::LenShort) ||
                   text_len == PosW'(lcd_pkg::LenLeft))) begin
        judged = lcd_pkg::EV_LEFT;
      end else if (upper == lcd_pkg::CharR && (text_len == PosW'(lcd_pkg::LenShort) ||
                   text_len == PosW'(lcd_pkg::LenRight))) begin
        judged = lcd_pkg::EV_RIGHT;
      end else if (upper == lcd_pkg::CharS && (text_len == PosW'(lcd_pkg::LenShort) ||
                   text_len == PosW'(lcd_pkg::LenStop))) begin
        judged = lcd_pkg::EV_STOP;
      end else if (upper == lcd_pkg::CharP && (text_len == PosW'(lcd_pkg::LenShort) ||
                   text_len == PosW'(lcd_pkg::LenPing))) begin
        judged = lcd_pkg::EV_PING;
      end else begin
        judged = lcd_pkg::EV_UNKNOWN;
      end
    end
  end

  assign matched = judged != lcd_pkg::EV_UNKNOWN;

  always_comb begin
    line_length_next    = line_length;
    text_start_next     = text_start;
    text_end_next       = text_end;
    first_letter_next   = first_letter;
    seen_text_next      = seen_text;
    accepted_count_next = accepted_count;
    rejected_count_next = rejected_count;
    result.valid        = 1'b0;
    result.kind         = judged;

    if (is_eol) begin
      if (line_length != '0) begin
        result.valid = 1'b1;
        if (matched) begin
          accepted_count_next = accepted_count + 32'd1;
        end else begin
          rejected_count_next = rejected_count + 32'd1;
        end
        line_length_next  = '0;
        text_start_next   = '0;
        text_end_next     = '0;
        first_letter_next = '0;
        seen_text_next    = 1'b0;
      end
    end else if (has_room) begin
      if (!is_blank) begin
        if (!seen_text) begin
          seen_text_next    = 1'b1;
          text_start_next   = line_length;
          first_letter_next = rx_byte;
        end
        text_end_next = line_length + PosW'(1);
      end
      line_length_next = line_length + PosW'(1);
    end else begin
      // Line full: drop it together with this byte.
      result.valid        = 1'b1;
      result.kind         = lcd_pkg::EV_OVERLONG;
      rejected_count_next = rejected_count + 32'd1;
      line_length_next    = '0;
      text_start_next     = '0;
      text_end_next       = '0;
      first_letter_next   = '0;
      seen_text_next      = 1'b0;
    end

    result.accepted = accepted_count_next;
    result.rejected = rejected_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length    <= '0;
      text_start     <= '0;
      text_end       <= '0;
      first_letter   <= '0;
      seen_text      <= 1'b0;
      accepted_count <= '0;
      rejected_count <= '0;
    end else if (step) begin
      line_length    <= line_length_next;
      text_start     <= text_start_next;
      text_end       <= text_end_next;
      first_letter   <= first_letter_next;
      seen_text      <= seen_text_next;
      accepted_count <= accepted_count_next;
      rejected_count <= rejected_count_next;
    end
  end

endmodule

### hw/rtl/line_command_decoder.sv
// Top level of the line command decoder: input register, line tracker, result register.
//
// Usage
//   Bytes from a serial receiver arrive one word at a time on the s_axis channel
//   (tdata[7:0] = received byte). CR or LF closes a non-empty line; the trimmed
//   line is judged as forward, left, right, stop or ping (single letter or the
//   full word length), otherwise unknown. A line that has grown to
//   LINE_CAPACITY-1 bytes is dropped by the next ordinary byte (overlong).
//   Each judged or dropped line yields one word on m_axis: tuser = event kind,
//   tdata = accepted and rejected totals after the event. Other bytes yield none.
// Timing
//   A byte is held in the input register, then its result is loaded into the
//   result register. One byte is taken every cycle while the result register is
//   free or being emptied; the line state update is a single short pass.
// Reset
//   rst (synchronous) empties both registers and clears line state and totals.
// Stall
//   While m_axis_tready is low the result word holds; one more byte still enters
//   the input register, and s_axis_tready then drops until the result is taken.
module line_command_decoder #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] accepted_total, [63:32] rejected_total
  output logic [2:0]  m_axis_tuser    // [2:0] event_kind
);

  logic                 in_valid;
  logic [7:0]           in_byte;
  logic                 advance;
  logic                 step;
  lcd_pkg::lcd_result_t result;

  logic                 out_valid;
  lcd_pkg::event_kind_t out_kind;
  logic [31:0]          out_accepted;
  logic [31:0]          out_rejected;

  // Result register free (or being emptied this cycle).
  assign advance       = !out_valid || m_axis_tready;
  assign step          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  lcd_line_tracker #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_tracker (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (in_byte),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind     <= result.kind;
      out_accepted <= result.accepted;
      out_rejected <= result.rejected;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tdata  = {out_rejected, out_accepted};

endmodule

### hw/rtl/lcd_checker.sv
// Port-level checks for the line command decoder, bound to the top level.
module lcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  logic [31:0] last_accepted;
  logic [31:0] last_rejected;
  logic        out_fire;
  logic        is_command;

  assign out_fire   = m_axis_tvalid && m_axis_tready;
  assign is_command = m_axis_tuser == lcd_pkg::EV_FORWARD || m_axis_tuser == lcd_pkg::EV_LEFT ||
                      m_axis_tuser == lcd_pkg::EV_RIGHT || m_axis_tuser == lcd_pkg::EV_STOP ||
                      m_axis_tuser == lcd_pkg::EV_PING;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_accepted <= '0;
      last_rejected <= '0;
    end else if (out_fire) begin
      last_accepted <= m_axis_tdata[31:0];
      last_rejected <= m_axis_tdata[63:32];
    end
  end

  // Every event moves exactly one total by one, chosen by its kind.
  a_totals_step: assert property (@(posedge clk) disable iff (rst)
    out_fire |-> (is_command
      ? (m_axis_tdata[31:0] == last_accepted + 32'd1 && m_axis_tdata[63:32] == last_rejected)
      : (m_axis_tdata[63:32] == last_rejected + 32'd1 && m_axis_tdata[31:0] == last_accepted)))
    else $error("totals do not follow event kind");

  // An empty result register never blocks input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with no pending result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result shown right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result word changed");

endmodule

bind line_command_decoder lcd_checker u_lcd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### verif/testbench.sv
// Self-checking bench for the line command decoder: directed and random byte streams.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LineCap    = 64;
  localparam int PosW       = $clog2(LineCap);
  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 150;
  localparam int DrainCycles = 20;
  localparam int ByteTarget = 950;

  typedef bit [PosW-1:0] pos_t;

  typedef struct {
    lcd_pkg::event_kind_t kind;
    bit [31:0]            accepted;
    bit [31:0]            rejected;
  } line_event_t;

  // Tracks the line being assembled and queues the event each closing or dropping byte yields.
  class line_event_board;
    pos_t        line_len;
    pos_t        span_start;  // first non-blank position
    pos_t        span_end;    // one past the last non-blank position
    bit [7:0]    lead_char;
    bit          has_text;
    bit [31:0]   accepted;
    bit [31:0]   rejected;
    line_event_t due_events[$];
    int          mismatches;

    function void clear_line();
      line_len   = '0;
      span_start = '0;
      span_end   = '0;
      lead_char  = '0;
      has_text   = 1'b0;
    endfunction

    // Only the first letter and the trimmed span length decide the command.
    function lcd_pkg::event_kind_t judge();
      pos_t     span;
      bit [7:0] up;
      if (!has_text || span_end <= span_start) return lcd_pkg::EV_UNKNOWN;
      span = span_end - span_start;
      up = (lead_char >= lcd_pkg::CharLowA && lead_char <= lcd_pkg::CharLowZ)
           ? lead_char - lcd_pkg::CaseGap : lead_char;
      case (up)
        lcd_pkg::CharF:
          if (span == lcd_pkg::LenShort || span == lcd_pkg::LenForward)
            return lcd_pkg::EV_FORWARD;
        lcd_pkg::CharL:
          if (span == lcd_pkg::LenShort || span == lcd_pkg::LenLeft)
            return lcd_pkg::EV_LEFT;
        lcd_pkg::CharR:
          if (span == lcd_pkg::LenShort || span == lcd_pkg::LenRight)
            return lcd_pkg::EV_RIGHT;
        lcd_pkg::CharS:
          if (span == lcd_pkg::LenShort || span == lcd_pkg::LenStop)
            return lcd_pkg::EV_STOP;
        lcd_pkg::CharP:
          if (span == lcd_pkg::LenShort || span == lcd_pkg::LenPing)
            return lcd_pkg::EV_PING;
        default: ;
      endcase
      return lcd_pkg::EV_UNKNOWN;
    endfunction

    function void note_byte(bit [7:0] b);
      line_event_t ev;
      if (b == lcd_pkg::CharLf || b == lcd_pkg::CharCr) begin
        if (line_len == 0) return;  // line end with nothing stored: no word
        ev.kind = judge();
        if (ev.kind == lcd_pkg::EV_UNKNOWN) rejected += 1;
        else accepted += 1;
      end else if (line_len < LineCap - 1) begin
        if (!(b == lcd_pkg::CharSpace || b == lcd_pkg::CharTab ||
              b == lcd_pkg::CharVtab || b == lcd_pkg::CharFf)) begin
          if (!has_text) begin
            has_text   = 1'b1;
            span_start = line_len;
            lead_char  = b;
          end
          span_end = line_len + 1'b1;
        end
        line_len = line_len + 1'b1;
        return;
      end else begin
        // full line: this byte is thrown away along with the line
        ev.kind = lcd_pkg::EV_OVERLONG;
        rejected += 1;
      end
      clear_line();
      ev.accepted = accepted;
      ev.rejected = rejected;
      due_events.push_back(ev);
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_word(logic [2:0] kind, logic [63:0] data);
      line_event_t want;
      if (due_events.size() == 0) begin
        report($sformatf("word with nothing pending, kind %0d", kind));
        return;
      end
      want = due_events.pop_front();
      if (kind !== 3'(want.kind))
        report($sformatf("event kind %0d, want %0d", kind, want.kind));
      if (data[31:0] !== want.accepted)
        report($sformatf("accepted total %0d, want %0d", data[31:0], want.accepted));
      if (data[63:32] !== want.rejected)
        report($sformatf("rejected total %0d, want %0d", data[63:32], want.rejected));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // [31:0] accepted_total, [63:32] rejected_total
  logic [2:0]  m_axis_tuser;   // [2:0] event_kind

  line_event_board sb = new;
  bit    steady_feed;
  bit    steady_drain;
  bit    hold_request;
  int    bytes_sent;
  string cmd_word [5] = '{"forward", "left", "right", "stop", "ping"};

  line_command_decoder #(.LINE_CAPACITY(LineCap)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one byte after a random gap; valid stays up afterwards unless the next gap lowers it.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = steady_feed ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.due_events.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0:       return lcd_pkg::CharSpace;
      1:       return lcd_pkg::CharTab;
      2:       return lcd_pkg::CharVtab;
      default: return lcd_pkg::CharFf;
    endcase
  endfunction

  // Any byte that does not end a line, blanks included.
  function automatic logic [7:0] body_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == lcd_pkg::CharLf || b == lcd_pkg::CharCr);
    return b;
  endfunction

  function automatic logic [7:0] end_char();
    return $urandom_range(0, 1) ? lcd_pkg::CharCr : lcd_pkg::CharLf;
  endfunction

  // A line built around a command letter: short form, full-length word, or a random length.
  task automatic send_command_line();
    int         shape;
    int         len;
    string      w;
    logic [7:0] c;
    w = cmd_word[$urandom_range(0, 4)];
    shape = $urandom_range(0, 9);
    len = (shape < 4) ? 1 : (shape < 7) ? w.len() : $urandom_range(2, 9);
    repeat ($urandom_range(0, 2)) send_byte(blank_char());
    for (int i = 0; i < len; i++) begin
      if (i == 0 || (shape >= 4 && shape < 7 && $urandom_range(0, 3) != 0)) c = w[i];
      else c = body_char();
      if (c >= lcd_pkg::CharLowA && c <= lcd_pkg::CharLowZ && $urandom_range(0, 1))
        c = c - lcd_pkg::CaseGap;
      send_byte(c);
    end
    repeat ($urandom_range(0, 2)) send_byte(blank_char());
    send_byte(end_char());
    if ($urandom_range(0, 5) == 0) send_byte(end_char());  // second line end: the line it closes is empty
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Lines at the capacity boundary: a command in the last free slot, an overrun, a full line.
  task automatic send_long_line(input int shape);
    case (shape)
      0: begin
        repeat (LineCap - 2) send_byte(blank_char());
        send_byte($urandom_range(0, 1) ? lcd_pkg::CharS : lcd_pkg::CharS + lcd_pkg::CaseGap);
      end
      1: repeat (LineCap - 1 + $urandom_range(1, 3)) send_byte(body_char());
      default: repeat (LineCap - 1) send_byte(body_char());
    endcase
    send_byte(end_char());
  endtask

  task automatic send_random_line();
    int pick;
    steady_feed = ($urandom_range(0, 3) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 70) send_command_line();
    else if (pick < 97) send_noise();
    else send_long_line($urandom_range(0, 2));
  endtask

  initial begin : stimulus
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: short forms, a padded full word, an empty line end, blank-only line, high and zero bytes
    send_text("F");  send_byte(lcd_pkg::CharLf);
    send_text("l");  send_byte(lcd_pkg::CharCr);
    send_byte(lcd_pkg::CharCr);
    send_byte(lcd_pkg::CharSpace); send_byte(lcd_pkg::CharTab);
    send_byte(lcd_pkg::CharVtab);  send_byte(lcd_pkg::CharFf);
    send_byte(lcd_pkg::CharLf);
    send_byte(8'hFF); send_byte(lcd_pkg::CharLf);
    send_byte(8'h00); send_byte(lcd_pkg::CharLf);
    send_text("  stop"); send_byte(lcd_pkg::CharCr);
    send_text("P");  send_byte(lcd_pkg::CharLf);
    pause_until_drained();

    for (int k = 0; k < 3; k++) send_long_line(k);
    while (bytes_sent < ByteTarget / 2) send_random_line();

    // results held back for a long stretch while stop lines keep coming
    hold_request = 1'b1;
    steady_feed  = 1'b1;
    repeat (30) begin
      send_byte(lcd_pkg::CharS);
      send_byte(end_char());
    end
    pause_until_drained();

    while (bytes_sent < ByteTarget) send_random_line();
    s_axis_tvalid <= 1'b0;

    while (sb.due_events.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin : result_sink
    int wait_cycles;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        wait_cycles = HoldCycles;
      end else begin
        wait_cycles = steady_drain ? 0 : $urandom_range(0, 3);
      end
      if (wait_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_word(m_axis_tuser, m_axis_tdata);
      if ($urandom_range(0, 15) == 0) steady_drain = !steady_drain;
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

endmodule
